@@ hw/rtl/htps_pkg.sv @@
// ----------------------------------------------------------------------------
// htps_pkg
// Shared types, constants and score helpers for the hash table probe/store
// block.
// ----------------------------------------------------------------------------
package htps_pkg;

  localparam int unsigned HTPS_ENTRIES = 65536;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned PLY_W    = 8;
  localparam int unsigned MOVE_W   = 16;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned DEPTH_W  = 8;
  localparam int unsigned BOUND_W  = 2;
  localparam int unsigned GEN_W    = 8;
  localparam int unsigned THR_W    = 15;

  localparam int unsigned S_TDATA_W = 136;
  localparam int unsigned M_TDATA_W = 64;
  localparam int unsigned M_TUSER_W = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_THR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_GEN = 1'b1;

  localparam logic [THR_W-1:0] MATE_THR_RST   = 15'd30000;
  localparam logic [GEN_W-1:0] SEARCH_GEN_RST = 8'd0;

  // opcodes
  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // bound codes
  localparam logic [BOUND_W-1:0] BOUND_NONE  = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd3;

  typedef struct packed {
    logic                      valid;
    logic                      pv;
    logic [DEPTH_W-1:0]        depth;
    logic [GEN_W-1:0]          gen;
    logic [BOUND_W-1:0]        bound;
    logic signed [SCORE_W-1:0] eval;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  typedef struct packed {
    logic                      opcode;
    logic [KEY_W-1:0]          key;
    logic [PLY_W-1:0]          ply;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] static_eval;
    logic [BOUND_W-1:0]        bound;
    logic                      pv_flag;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic                      written;
    logic [MOVE_W-1:0]         hit_move;
    logic signed [SCORE_W-1:0] hit_score;
    logic signed [SCORE_W-1:0] hit_eval;
    logic [DEPTH_W-1:0]        hit_depth;
    logic [BOUND_W-1:0]        hit_bound;
    logic                      hit_pv;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;    // write zero at clear pointer, advance it
    logic load;      // capture input item, restart index reduction
    logic mod_step;  // one step of key reduction
    logic rd;        // read slot
    logic eval;      // decide, write slot, load result register
  } htps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic mod_done;
  } htps_sts_t;

  // Mate-range score shift by ply. up=1 moves away from root (store).
  function automatic logic signed [SCORE_W-1:0] mate_adjust(
    input logic signed [SCORE_W-1:0] s,
    input logic [PLY_W-1:0]          ply,
    input logic [THR_W-1:0]          thr,
    input logic                      up
  );
    logic signed [SCORE_W+1:0] sx;
    logic signed [SCORE_W+1:0] tx;
    logic signed [SCORE_W+1:0] px;
    logic signed [SCORE_W+1:0] v;
    sx = {{2{s[SCORE_W-1]}}, s};
    tx = signed'({3'b000, thr});
    px = signed'({10'd0, ply});
    if (sx >= tx) begin
      v = up ? (sx + px) : (sx - px);
    end else if (sx <= -tx) begin
      v = up ? (sx - px) : (sx + px);
    end else begin
      v = sx;
    end
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[SCORE_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/htps_ctrl.sv @@
// ----------------------------------------------------------------------------
// htps_ctrl
// Sequencer: clearing pass, item capture, slot index, read, evaluate.
// ----------------------------------------------------------------------------
module htps_ctrl
  import htps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output htps_cmd_t cmd_o,
  input  htps_sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_EVAL
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_wr   = (state_q == ST_CLEAR);
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mod_step = (state_q == ST_INDEX) && !sts_i.mod_done;
    cmd_o.rd       = (state_q == ST_INDEX) && sts_i.mod_done;
    cmd_o.eval     = (state_q == ST_EVAL) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_INDEX;
        end
        ST_INDEX: begin
          if (sts_i.mod_done) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/htps_dp.sv @@
// ----------------------------------------------------------------------------
// htps_dp
// Datapath: config regs, key reduction, slot memory, replace decision,
// result register.
// ----------------------------------------------------------------------------
module htps_dp
  import htps_pkg::*;
#(
  parameter int unsigned ENTRIES = HTPS_ENTRIES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  in_item_t             in_item_i,
  output out_item_t            out_item_o,
  input  htps_cmd_t            cmd_i,
  output htps_sts_t            sts_o
);

  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned REM_W   = IDX_W + 1;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned STEPS   = KEY_W / DIG_W;
  localparam int unsigned CNT_W   = $clog2(STEPS);
  localparam bit          IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;
  localparam logic [REM_W-1:0] ENT_C  = REM_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_C = IDX_W'(ENTRIES - 1);

  entry_t mem [ENTRIES];

  logic [THR_W-1:0] thr_q;
  logic [GEN_W-1:0] gen_q;

  in_item_t         item_q;
  logic [KEY_W-1:0] sh_q, sh_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [IDX_W-1:0] clr_q;
  logic [IDX_W-1:0] idx;
  entry_t           rd_q;
  entry_t           new_e;
  out_item_t        out_q, out_d;
  logic             hit;
  logic             repl;
  logic             do_wr;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= MATE_THR_RST;
      gen_q <= SEARCH_GEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MATE_THR:   thr_q <= cfg_data_i[THR_W-1:0];
        CFG_SEARCH_GEN: gen_q <= cfg_data_i[GEN_W-1:0];
        default: ;
      endcase
    end
  end

  // key mod ENTRIES, one nibble per cycle, MSB first
  always_comb begin
    logic [REM_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < DIG_W; i++) begin
      r = {r[REM_W-2:0], sh_q[KEY_W-1-i]};
      if (r >= ENT_C) r = r - ENT_C;
    end
    rem_d = r;
    sh_d  = sh_q << DIG_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else if (cmd_i.mod_step) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) done_q <= 1'b1;
      end
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
      sh_q   <= in_item_i.key;
      rem_q  <= '0;
    end else if (cmd_i.mod_step) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign idx = IS_POW2 ? item_q.key[IDX_W-1:0] : rem_q[IDX_W-1:0];

  assign sts_o.clr_last = (clr_q == LAST_C);
  assign sts_o.mod_done = IS_POW2 ? 1'b1 : done_q;

  // replacement order
  always_comb begin
    if (!rd_q.valid) begin
      repl = 1'b1;
    end else if (rd_q.move == '0 && item_q.move != '0) begin
      repl = 1'b1;
    end else if (rd_q.move != '0 && item_q.move == '0) begin
      repl = 1'b0;
    end else if (rd_q.gen != gen_q) begin
      repl = 1'b1;
    end else if (item_q.depth > rd_q.depth) begin
      repl = 1'b1;
    end else if (item_q.depth == rd_q.depth) begin
      repl = (item_q.bound == BOUND_EXACT && rd_q.bound != BOUND_EXACT) ||
             (item_q.bound != BOUND_UPPER && rd_q.bound == BOUND_UPPER);
    end else begin
      repl = 1'b0;
    end
  end

  assign hit   = (item_q.opcode == OP_PROBE) && rd_q.valid &&
                 (rd_q.tag == item_q.key[KEY_W-1:KEY_W-TAG_W]);
  assign do_wr = cmd_i.eval && (item_q.opcode == OP_STORE) && repl;

  always_comb begin
    new_e       = '0;
    new_e.valid = 1'b1;
    new_e.pv    = item_q.pv_flag;
    new_e.depth = item_q.depth;
    new_e.gen   = gen_q;
    new_e.bound = item_q.bound;
    new_e.eval  = item_q.static_eval;
    new_e.score = mate_adjust(item_q.score, item_q.ply, thr_q, 1'b1);
    new_e.move  = item_q.move;
    new_e.tag   = item_q.key[KEY_W-1:KEY_W-TAG_W];
  end

  always_comb begin
    out_d         = '0;
    out_d.written = (item_q.opcode == OP_STORE) && repl;
    if (hit) begin
      out_d.hit       = 1'b1;
      out_d.hit_move  = rd_q.move;
      out_d.hit_score = mate_adjust(rd_q.score, item_q.ply, thr_q, 1'b0);
      out_d.hit_eval  = rd_q.eval;
      out_d.hit_depth = rd_q.depth;
      out_d.hit_bound = rd_q.bound;
      out_d.hit_pv    = rd_q.pv;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[clr_q] <= '0;
    end else if (do_wr) begin
      mem[idx] <= new_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) out_q <= out_d;
  end

  assign out_item_o = out_q;

endmodule

@@ hw/rtl/hash_table_probe_store_replace.sv @@
// ----------------------------------------------------------------------------
// hash_table_probe_store_replace
// Direct-mapped transposition table with depth-preferred replacement.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request item: tuser is the opcode (probe or store),
//   tdata the key and store payload. m_axis returns exactly one item per
//   request: tuser holds hit and written, tdata the probed slot contents
//   (all zero on a miss or a store).
//   The cfg channel writes mate_threshold (index 0) or search_generation
//   (index 1), always ready; the user must write it only while idle (unchecked).
// Timing:
//   ENTRIES a power of two: the slot index is the low key bits; the slot is
//   read, then, once the output is free, the result is registered and
//   m_axis_tvalid rises; a new item is taken only after that. Otherwise the
//   slot index comes from a key reduction taking 4 key bits per cycle. Each
//   item costs one slot read and at most one write on the table memory.
// Reset:
//   Control state clears at once; then a clearing pass writes every slot to
//   zero, one per cycle, with s_axis_tready held low.
// Stall:
//   A result waits in the output register; the next request is already
//   accepted and worked on, and stops before overwriting it.
// ----------------------------------------------------------------------------
module hash_table_probe_store_replace
  import htps_pkg::*;
#(
  parameter int unsigned ENTRIES = HTPS_ENTRIES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [63:0] key, [71:64] ply, [87:72] move, [103:88] score,
  // [111:104] depth, [127:112] static_eval, [129:128] bound, [130] pv_flag
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] opcode
  input  logic [0:0]           s_axis_tuser,
  // result
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] hit_move, [31:16] hit_score, [47:32] hit_eval,
  // [55:48] hit_depth, [57:56] hit_bound, [58] hit_pv
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] hit, [1] written
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  htps_cmd_t cmd;
  htps_sts_t sts;
  in_item_t  in_item;
  out_item_t out_item;

  // unpack request
  always_comb begin
    in_item.opcode      = s_axis_tuser[0];
    in_item.key         = s_axis_tdata[63:0];
    in_item.ply         = s_axis_tdata[71:64];
    in_item.move        = s_axis_tdata[87:72];
    in_item.score       = s_axis_tdata[103:88];
    in_item.depth       = s_axis_tdata[111:104];
    in_item.static_eval = s_axis_tdata[127:112];
    in_item.bound       = s_axis_tdata[129:128];
    in_item.pv_flag     = s_axis_tdata[130];
  end

  // config is taken in any state
  assign cfg_ready_o = 1'b1;

  htps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  htps_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item),
    .out_item_o  (out_item),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // pack result
  assign m_axis_tuser = {out_item.written, out_item.hit};
  assign m_axis_tdata = {5'd0, out_item.hit_pv, out_item.hit_bound,
                         out_item.hit_depth, out_item.hit_eval,
                         out_item.hit_score, out_item.hit_move};

endmodule

@@ hw/rtl/htps_checker.sv @@
// ----------------------------------------------------------------------------
// htps_checker
// Port-level checks for the hash table probe/store block.
// ----------------------------------------------------------------------------
module htps_checker
  import htps_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // a request is either a probe or a store, never both outcomes
  a_hit_xor_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("hit and written both set");

  // miss or store returns zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("payload not zero without hit");

  // one request in flight: no back-to-back accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous still in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind hash_table_probe_store_replace htps_checker u_htps_checker (.*);
